[hdl/lbc_pkg.sv]
// Shared types, constants and codes for the labeled region box crop block.
package lbc_pkg;

    localparam int MAX_DIM  = 256;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = COORD_W + 1;
    localparam int EXT_W    = COORD_W + 1;
    localparam int MAT_W    = 8;
    localparam int LABEL_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_X  = 2'd0,
        REG_DIM_Y  = 2'd1,
        REG_DIM_Z  = 2'd2,
        REG_TARGET = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_COPY = 1'b1
    } op_t;

    typedef enum logic {
        KIND_SUMMARY = 1'b0,
        KIND_CELL    = 1'b1
    } kind_t;

    // Current voxel position plus raster markers
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               at_origin;
        logic               at_end;
    } pos_t;

    typedef struct packed {
        kind_t              kind;
        logic               found;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] origin_z;
        logic [EXT_W-1:0]   extent_x;
        logic [EXT_W-1:0]   extent_y;
        logic [EXT_W-1:0]   extent_z;
        logic [MAT_W-1:0]   cell_value;
        logic               last;
    } result_t;

    // Out-of-range sizes: zero counts as one, anything above MAX_DIM as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

[hdl/labeled_region_box_crop.sv]
// Top level of the labeled region bounding box crop block.
//
// Usage: the parent voxel grid is streamed in raster order (x fastest, then
// y, then z), one voxel per input word; tuser selects the pass (0 scan,
// 1 copy). Positions come from internal counters that advance on every
// accepted word and wrap to the origin after the last voxel of the grid.
// A scan pass builds the min/max box of voxels whose label equals the
// target and emits one summary word (tuser 0) on its last voxel. A copy
// pass emits one cell word (tuser 1) per voxel inside the box; tlast marks
// the final cell. Target 0 or an empty scan gives found=0 and no cells.
// Config: write cfg_we/cfg_index/cfg_data while idle; any write returns the
// position counters to the origin. Sizes of 0 count as 1, above 256 as 256.
// Timing: one input word per cycle while the output buffer has room; a
// result is registered into it when its input word is taken. The per-voxel
// compare, min/max and counter update are combinational ahead of a two-word
// output buffer, so the input keeps moving while one result waits.
// Stall: when the receiver holds tready low and both buffer words are full,
// s_axis_tready drops until a word leaves. Reset empties the buffer, clears
// the box and counters and sets all sizes to 1 and the target to 0.
module labeled_region_box_crop (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]         cfg_data,
    // Voxel input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lbc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // material[7:0], label[23:8]
    input  logic                              s_axis_tuser,  // op
    // Result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found[0], origin_x[8:1], origin_y[16:9], origin_z[24:17], extent_x[33:25],
    // extent_y[42:34], extent_z[51:43], cell_value[59:52], zero fill[63:60]
    output logic [lbc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,  // kind
    output logic                              m_axis_tlast   // last
);
    import lbc_pkg::*;

    pos_t               pos;
    logic [LABEL_W-1:0] target;
    logic               step;
    logic               res_valid;
    result_t            res;
    result_t            out_res;

    assign step = s_axis_tvalid && s_axis_tready;

    lbc_cfgpos u_cfgpos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .pos       (pos),
        .target    (target)
    );

    lbc_box u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .op        (s_axis_tuser),
        .material  (s_axis_tdata[MAT_W-1:0]),
        .label     (s_axis_tdata[MAT_W+LABEL_W-1:MAT_W]),
        .pos       (pos),
        .target    (target),
        .res_valid (res_valid),
        .res       (res)
    );

    lbc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {4'b0, out_res.cell_value,
                           out_res.extent_z, out_res.extent_y, out_res.extent_x,
                           out_res.origin_z, out_res.origin_y, out_res.origin_x,
                           out_res.found};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

[hdl/lbc_cfgpos.sv]
// Configuration registers and raster position counter.
module lbc_cfgpos (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              step,
    output lbc_pkg::pos_t                     pos,
    output logic [lbc_pkg::LABEL_W-1:0]       target
);
    import lbc_pkg::*;

    logic [DIM_W-1:0]   dim_x_reg, dim_y_reg, dim_z_reg;
    logic [LABEL_W-1:0] target_reg;
    logic [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [COORD_W-1:0] px_next, py_next, pz_next;
    logic               x_wrap, y_wrap, z_wrap;
    logic [DIM_W-1:0]   dim_in;

    assign dim_in = clamp_dim(cfg_data[DIM_W-1:0]);

    // End-of-axis flags, compared one wider than the counter
    assign x_wrap = ({1'b0, px_reg} + DIM_W'(1)) >= dim_x_reg;
    assign y_wrap = ({1'b0, py_reg} + DIM_W'(1)) >= dim_y_reg;
    assign z_wrap = ({1'b0, pz_reg} + DIM_W'(1)) >= dim_z_reg;

    always_comb
    begin
        px_next = px_reg;
        py_next = py_reg;
        pz_next = pz_reg;
        if (!x_wrap)
        begin
            px_next = px_reg + COORD_W'(1);
        end
        else
        begin
            px_next = '0;
            if (!y_wrap)
            begin
                py_next = py_reg + COORD_W'(1);
            end
            else
            begin
                py_next = '0;
                pz_next = z_wrap ? '0 : pz_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg  <= DIM_W'(1);
            dim_y_reg  <= DIM_W'(1);
            dim_z_reg  <= DIM_W'(1);
            target_reg <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            pz_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DIM_X:  dim_x_reg  <= dim_in;
                REG_DIM_Y:  dim_y_reg  <= dim_in;
                REG_DIM_Z:  dim_z_reg  <= dim_in;
                REG_TARGET: target_reg <= cfg_data[LABEL_W-1:0];
                default:    target_reg <= target_reg;
            endcase
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
        end
        else if (step)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
    end

    assign pos.x         = px_reg;
    assign pos.y         = py_reg;
    assign pos.z         = pz_reg;
    assign pos.at_origin = (px_reg == '0) && (py_reg == '0) && (pz_reg == '0);
    assign pos.at_end    = x_wrap && y_wrap && z_wrap;
    assign target        = target_reg;

endmodule

[hdl/lbc_box.sv]
// Bounding box tracker and result former for scan and copy words.
module lbc_box (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          op,
    input  logic [lbc_pkg::MAT_W-1:0]     material,
    input  logic [lbc_pkg::LABEL_W-1:0]   label,
    input  lbc_pkg::pos_t                 pos,
    input  logic [lbc_pkg::LABEL_W-1:0]   target,
    output logic                          res_valid,
    output lbc_pkg::result_t              res
);
    import lbc_pkg::*;

    logic [COORD_W-1:0] min_reg [3];
    logic [COORD_W-1:0] max_reg [3];
    logic [COORD_W-1:0] min_next [3];
    logic [COORD_W-1:0] max_next [3];
    logic [COORD_W-1:0] min_eff [3];
    logic [COORD_W-1:0] max_eff [3];
    logic [COORD_W-1:0] p [3];
    logic [EXT_W-1:0]   ext [3];
    logic               hit_reg, hit_next, hit_eff;
    logic               match, is_scan, in_box, last_cell;

    assign p[0] = pos.x;
    assign p[1] = pos.y;
    assign p[2] = pos.z;

    assign match   = (target != '0) && (label == target);
    assign is_scan = (op_t'(op) == OP_SCAN);
    // A scan word at the origin starts from a clean box
    assign hit_eff = (is_scan && pos.at_origin) ? 1'b0 : hit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            min_eff[i] = (is_scan && pos.at_origin) ? '1 : min_reg[i];
            max_eff[i] = (is_scan && pos.at_origin) ? '0 : max_reg[i];
            min_next[i] = min_eff[i];
            max_next[i] = max_eff[i];
            if (match)
            begin
                if (!hit_eff || p[i] < min_eff[i])
                begin
                    min_next[i] = p[i];
                end
                if (!hit_eff || p[i] > max_eff[i])
                begin
                    max_next[i] = p[i];
                end
            end
            ext[i] = {1'b0, max_next[i]} - {1'b0, min_next[i]} + EXT_W'(1);
        end
        hit_next = hit_eff || match;
    end

    always_comb
    begin
        in_box    = 1'b1;
        last_cell = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (p[i] < min_reg[i] || p[i] > max_reg[i])
            begin
                in_box = 1'b0;
            end
            if (p[i] != max_reg[i])
            begin
                last_cell = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= '1;
                max_reg[i] <= '0;
            end
        end
        else if (step && is_scan)
        begin
            hit_reg <= hit_next;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= min_next[i];
                max_reg[i] <= max_next[i];
            end
        end
    end

    always_comb
    begin
        res = '0;
        res_valid = 1'b0;
        if (is_scan)
        begin
            res_valid = pos.at_end;
            res.kind  = KIND_SUMMARY;
            res.found = hit_next;
            if (hit_next)
            begin
                res.origin_x = min_next[0];
                res.origin_y = min_next[1];
                res.origin_z = min_next[2];
                res.extent_x = ext[0];
                res.extent_y = ext[1];
                res.extent_z = ext[2];
            end
        end
        else
        begin
            res_valid      = hit_reg && in_box;
            res.kind       = KIND_CELL;
            res.cell_value = match ? material : '0;
            res.last       = last_cell;
        end
    end

endmodule

[hdl/lbc_obuf.sv]
// Two-entry output buffer that decouples the result channel from the input.
module lbc_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lbc_pkg::result_t  push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output lbc_pkg::result_t  out_data
);
    import lbc_pkg::*;

    result_t    head_reg, tail_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            case ({push, pop})
                2'b01:   count_reg <= count_reg - 2'd1;
                2'b10:   count_reg <= count_reg + 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_reg <= push_data;
                end
                else
                begin
                    head_reg <= tail_reg;
                    tail_reg <= push_data;
                end
            end
            2'b01:
            begin
                head_reg <= tail_reg;
            end
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_reg <= push_data;
                end
                else
                begin
                    tail_reg <= push_data;
                end
            end
            default:
            begin
                head_reg <= head_reg;
            end
        endcase
    end

endmodule

[tb/sv/labeled_region_box_crop_tb.sv]
// Self-checking testbench for the labeled region box crop block.
module labeled_region_box_crop_tb;
    import lbc_pkg::*;

    // Run length guard, far above any legal run.
    localparam int CYCLE_LIMIT    = 400000;
    // Minimum voxel words over all random phases, big grid included
    localparam int RANDOM_ITEMS   = 480;
    localparam int IDLE_PCT       = 29;
    // Each result is registered into a two-word output buffer.
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;

    // How one sweep over the grid picks its pass selector
    typedef enum int {
        SWEEP_SCAN,
        SWEEP_COPY,
        SWEEP_MIXED
    } sweep_t;

    // One directed step: either a register write or a voxel word
    typedef struct {
        bit                 is_write;
        cfg_idx_t           idx;
        logic [CFG_W-1:0]   value;
        op_t                op;
        logic [MAT_W-1:0]   mat;
        logic [LABEL_W-1:0] lab;
        bit                 typed;  // want holds a hand-written result
        result_t            want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // material[7:0], label[23:8]
    logic                  s_axis_tuser;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // found[0], origin_x[8:1], origin_y[16:9], origin_z[24:17], extent_x[33:25],
    // extent_y[42:34], extent_z[51:43], cell_value[59:52], zero fill[63:60]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;   // kind
    logic                  m_axis_tlast;   // last

    labeled_region_box_crop i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Crop model state: grid config, raster position and the running box
    logic [DIM_W-1:0]   grid_size [3];
    logic [LABEL_W-1:0] target_id;
    logic [COORD_W-1:0] voxel_pos [3];
    logic [COORD_W-1:0] box_lo [3];
    logic [COORD_W-1:0] box_hi [3];
    logic               region_seen;

    result_t            crop_words_due [$];   // oldest first
    logic [LABEL_W-1:0] grid_labels [];        // labels of the grid being streamed
    plan_row_t          plan [$];
    int unsigned        mismatches  = 0;
    int unsigned        cycle_count = 0;
    int                 rand_items  = 0;
    bit                 idle_on     = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Size 0 reads as 1, anything past the top as the top
    function automatic logic [DIM_W-1:0] bounded_size(input logic [DIM_W-1:0] raw);
        if (raw == '0)
        begin
            return DIM_W'(1);
        end
        if (raw > DIM_W'(MAX_DIM))
        begin
            return DIM_W'(MAX_DIM);
        end
        return raw;
    endfunction

    function automatic result_t summary_word(
        input logic               found,
        input logic [COORD_W-1:0] ox, oy, oz,
        input logic [EXT_W-1:0]   ex, ey, ez
    );
        result_t w;
        w          = '0;
        w.kind     = KIND_SUMMARY;
        w.found    = found;
        w.origin_x = ox;
        w.origin_y = oy;
        w.origin_z = oz;
        w.extent_x = ex;
        w.extent_y = ey;
        w.extent_z = ez;
        return w;
    endfunction

    function automatic result_t cell_word(input logic [MAT_W-1:0] v, input logic final_cell);
        result_t w;
        w            = '0;
        w.kind       = KIND_CELL;
        w.cell_value = v;
        w.last       = final_cell;
        return w;
    endfunction

    function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        plan_row_t r;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = value;
        r.op       = OP_SCAN;
        r.mat      = '0;
        r.lab      = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic plan_row_t voxel_row(
        input op_t op, input logic [MAT_W-1:0] mat, input logic [LABEL_W-1:0] lab
    );
        plan_row_t r;
        r.is_write = 1'b0;
        r.idx      = REG_DIM_X;
        r.value    = '0;
        r.op       = op;
        r.mat      = mat;
        r.lab      = lab;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic plan_row_t checked_row(
        input op_t op, input logic [MAT_W-1:0] mat, input logic [LABEL_W-1:0] lab,
        input result_t want
    );
        plan_row_t r;
        r       = voxel_row(op, mat, lab);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic string describe(input result_t w);
        return $sformatf(
            "kind=%0d found=%0d origin=(%0d,%0d,%0d) extent=(%0d,%0d,%0d) cell=%02h last=%0d",
            w.kind, w.found, w.origin_x, w.origin_y, w.origin_z,
            w.extent_x, w.extent_y, w.extent_z, w.cell_value, w.last);
    endfunction

    task automatic clear_region();
        int i;
        for (i = 0; i < 3; i++)
        begin
            box_lo[i] = '1;
            box_hi[i] = '0;
        end
        region_seen = 1'b0;
    endtask

    // Model of one voxel step: box update, summary or cell, raster advance
    task automatic crop_step(
        input  op_t                op,
        input  logic [MAT_W-1:0]   mat,
        input  logic [LABEL_W-1:0] lab,
        output bit                 emits,
        output result_t            word
    );
        bit hit;
        bit at_end;
        bit in_box;
        bit final_cell;
        int i;
        word   = '0;
        emits  = 1'b0;
        hit    = (target_id != '0) && (lab == target_id);
        at_end = 1'b1;
        for (i = 0; i < 3; i++)
        begin
            if ({1'b0, voxel_pos[i]} + 1'b1 != grid_size[i])
            begin
                at_end = 1'b0;
            end
        end

        if (op == OP_SCAN)
        begin
            // a scan at the origin starts a fresh box
            if (voxel_pos[0] == '0 && voxel_pos[1] == '0 && voxel_pos[2] == '0)
            begin
                clear_region();
            end
            if (hit)
            begin
                for (i = 0; i < 3; i++)
                begin
                    if (!region_seen || voxel_pos[i] < box_lo[i])
                    begin
                        box_lo[i] = voxel_pos[i];
                    end
                    if (!region_seen || voxel_pos[i] > box_hi[i])
                    begin
                        box_hi[i] = voxel_pos[i];
                    end
                end
                region_seen = 1'b1;
            end
            if (at_end)
            begin
                emits = 1'b1;
                word  = summary_word(1'b0, '0, '0, '0, '0, '0, '0);
                if (region_seen)
                begin
                    word = summary_word(1'b1, box_lo[0], box_lo[1], box_lo[2],
                        {1'b0, box_hi[0]} - {1'b0, box_lo[0]} + 1'b1,
                        {1'b0, box_hi[1]} - {1'b0, box_lo[1]} + 1'b1,
                        {1'b0, box_hi[2]} - {1'b0, box_lo[2]} + 1'b1);
                end
            end
        end
        else if (region_seen)
        begin
            in_box     = 1'b1;
            final_cell = 1'b1;
            for (i = 0; i < 3; i++)
            begin
                if (voxel_pos[i] < box_lo[i] || voxel_pos[i] > box_hi[i])
                begin
                    in_box = 1'b0;
                end
                if (voxel_pos[i] != box_hi[i])
                begin
                    final_cell = 1'b0;
                end
            end
            if (in_box)
            begin
                emits = 1'b1;
                word  = cell_word(hit ? mat : '0, final_cell);
            end
        end

        // raster order, x fastest, wraps to the origin after the last voxel
        if ({1'b0, voxel_pos[0]} + 1'b1 < grid_size[0])
        begin
            voxel_pos[0]++;
        end
        else
        begin
            voxel_pos[0] = '0;
            if ({1'b0, voxel_pos[1]} + 1'b1 < grid_size[1])
            begin
                voxel_pos[1]++;
            end
            else
            begin
                voxel_pos[1] = '0;
                if ({1'b0, voxel_pos[2]} + 1'b1 < grid_size[2])
                begin
                    voxel_pos[2]++;
                end
                else
                begin
                    voxel_pos[2] = '0;
                end
            end
        end
    endtask

    // Drive one voxel word; model it at the edge where it is taken
    task automatic send_voxel(
        input op_t                op,
        input logic [MAT_W-1:0]   mat,
        input logic [LABEL_W-1:0] lab,
        input bit                 typed,
        input result_t            want
    );
        bit      emits;
        result_t predicted;
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {lab, mat};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        crop_step(op, mat, lab, emits, predicted);
        if (typed)
        begin
            crop_words_due.push_back(want);
        end
        else if (emits)
        begin
            crop_words_due.push_back(predicted);
        end
    endtask

    // Stop sending and hold off until every due word is out, plus a margin
    // for voxels that produce nothing but may still be in the pipe.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (crop_words_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only called while idle; any write rewinds the raster
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        int i;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DIM_X:  grid_size[0] = bounded_size(value[DIM_W-1:0]);
            REG_DIM_Y:  grid_size[1] = bounded_size(value[DIM_W-1:0]);
            REG_DIM_Z:  grid_size[2] = bounded_size(value[DIM_W-1:0]);
            REG_TARGET: target_id    = value[LABEL_W-1:0];
            default:    ;
        endcase
        for (i = 0; i < 3; i++)
        begin
            voxel_pos[i] = '0;
        end
    endtask

    task automatic sweep(input sweep_t mode, input int count);
        op_t op;
        int  k;
        for (k = 0; k < count; k++)
        begin
            if (mode == SWEEP_MIXED)
            begin
                op = op_t'($urandom_range(0, 1));
            end
            else
            begin
                op = (mode == SWEEP_SCAN) ? OP_SCAN : OP_COPY;
            end
            send_voxel(op, MAT_W'($urandom), grid_labels[k], 1'b0, '0);
            rand_items++;
        end
    endtask

    // One configuration and a few passes over its grid. Small grids most of
    // the time; the big one puts 256 voxels on one axis to hit the origin and
    // extent extremes.
    task automatic run_phase(input bit big);
        logic [DIM_W-1:0]   raw [3];
        logic [LABEL_W-1:0] tgt;
        cfg_idx_t           idx;
        int                 axis;
        int                 start_idx;
        int                 voxels;
        int                 hit_pct;
        int                 extra;
        int                 stop;
        int                 k;
        axis = $urandom_range(0, 2);
        for (k = 0; k < 3; k++)
        begin
            if (big)
            begin
                // anything from 256 up reads as 256; zero on the other axes reads as 1
                raw[k] = (k == axis) ? DIM_W'($urandom_range(MAX_DIM, 2 * MAX_DIM - 1)) : '0;
            end
            else
            begin
                raw[k] = DIM_W'($urandom_range(0, 5));
            end
        end
        case ($urandom_range(0, 7))
            0:       tgt = '0;
            1:       tgt = '1;
            2:       tgt = LABEL_W'(1);
            default: tgt = LABEL_W'($urandom);
        endcase
        if (big && tgt == '0)
        begin
            tgt = '1;
        end

        wait_drained();
        start_idx = $urandom_range(0, 3);
        for (k = 0; k < 4; k++)
        begin
            idx = cfg_idx_t'(CFG_IDX_W'(start_idx + k));
            if (idx == REG_TARGET)
            begin
                write_reg(idx, tgt);
            end
            else
            begin
                // upper bits of the write are junk the block must drop
                write_reg(idx, {(CFG_W - DIM_W)'($urandom), raw[int'(idx)]});
            end
        end

        voxels      = int'(grid_size[0]) * int'(grid_size[1]) * int'(grid_size[2]);
        grid_labels = new[voxels];
        hit_pct     = big ? 10 : $urandom_range(0, 40);
        for (k = 0; k < voxels; k++)
        begin
            grid_labels[k] = ($urandom_range(0, 99) < hit_pct) ? tgt : LABEL_W'($urandom);
        end

        if (big)
        begin
            // region spans the whole axis: origin 0, extent 256
            grid_labels[0]          = tgt;
            grid_labels[voxels - 1] = tgt;
            sweep(SWEEP_SCAN, voxels);
        end
        else
        begin
            sweep(SWEEP_SCAN, voxels);
            sweep(SWEEP_COPY, voxels);
            // extra sweeps: repeats, mixed selectors, and some cut short so
            // the next sweep starts mid-grid
            extra = $urandom_range(0, 2);
            for (k = 0; k < extra; k++)
            begin
                stop = ($urandom_range(0, 4) == 0) ? $urandom_range(1, voxels) : voxels;
                sweep(sweep_t'($urandom_range(0, 2)), stop);
            end
        end
    endtask

    // Receiver: random back-pressure, set on the falling edge
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compare every taken result word with the oldest due word
    always @(posedge clk)
    begin : check_words
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got            = '0;
            got.kind       = kind_t'(m_axis_tuser);
            got.found      = m_axis_tdata[0];
            got.origin_x   = m_axis_tdata[8:1];
            got.origin_y   = m_axis_tdata[16:9];
            got.origin_z   = m_axis_tdata[24:17];
            got.extent_x   = m_axis_tdata[33:25];
            got.extent_y   = m_axis_tdata[42:34];
            got.extent_z   = m_axis_tdata[51:43];
            got.cell_value = m_axis_tdata[59:52];
            got.last       = m_axis_tlast;
            if (crop_words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected word at cycle %0d: %s", cycle_count, describe(got));
                end
            end
            else
            begin
                want = crop_words_due.pop_front();
                if (got !== want || m_axis_tdata[OUT_DATA_W-1:60] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("word mismatch at cycle %0d", cycle_count);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s fill=%h", describe(got),
                            m_axis_tdata[OUT_DATA_W-1:60]);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t row;
        int        k;
        int        phase;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DIM_X;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SCAN;

        // model matches the block's reset: 1x1x1 grid, target 0, empty box
        target_id = '0;
        for (k = 0; k < 3; k++)
        begin
            grid_size[k] = DIM_W'(1);
            voxel_pos[k] = '0;
        end
        clear_region();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed steps. Reset leaves a single-voxel grid with target 0.
        // target zero: the lone voxel ends the scan with nothing found
        plan.push_back(checked_row(OP_SCAN, 8'h00, 16'h0000,
            summary_word(1'b0, '0, '0, '0, '0, '0, '0)));
        // copy with no box yet: no word
        plan.push_back(voxel_row(OP_COPY, 8'hFF, 16'hFFFF));
        plan.push_back(reg_row(REG_TARGET, 16'hFFFF));
        plan.push_back(checked_row(OP_SCAN, 8'hFF, 16'hFFFF,
            summary_word(1'b1, '0, '0, '0, 9'd1, 9'd1, 9'd1)));
        plan.push_back(checked_row(OP_COPY, 8'hFF, 16'hFFFF, cell_word(8'hFF, 1'b1)));
        // label miss inside the box reads as zero
        plan.push_back(checked_row(OP_COPY, 8'h55, 16'h0000, cell_word(8'h00, 1'b1)));
        // a zero label never matches, even with target zero
        plan.push_back(reg_row(REG_TARGET, 16'h0000));
        plan.push_back(checked_row(OP_SCAN, 8'hAA, 16'h0000,
            summary_word(1'b0, '0, '0, '0, '0, '0, '0)));
        // 2x2x1 grid; junk in the upper bits, dim_z written as zero
        plan.push_back(reg_row(REG_DIM_X, 16'h0002));
        plan.push_back(reg_row(REG_DIM_Y, 16'hFE02));
        plan.push_back(reg_row(REG_DIM_Z, 16'hFE00));
        plan.push_back(reg_row(REG_TARGET, 16'hA5A5));
        plan.push_back(voxel_row(OP_SCAN, 8'h11, 16'hA5A5));
        plan.push_back(voxel_row(OP_SCAN, 8'h22, 16'h5A5A));
        plan.push_back(voxel_row(OP_SCAN, 8'h33, 16'h0000));
        plan.push_back(voxel_row(OP_SCAN, 8'h44, 16'hA5A5));
        plan.push_back(voxel_row(OP_COPY, 8'hF0, 16'hA5A5));
        plan.push_back(voxel_row(OP_COPY, 8'h0F, 16'hA5A5));
        plan.push_back(voxel_row(OP_COPY, 8'h80, 16'hA5A5));
        plan.push_back(voxel_row(OP_COPY, 8'h01, 16'h5A5A));
        // selector mixes scan and copy; the scan at the last voxel still reports
        plan.push_back(voxel_row(OP_SCAN, 8'h12, 16'hA5A5));
        plan.push_back(voxel_row(OP_COPY, 8'h34, 16'hA5A5));
        plan.push_back(voxel_row(OP_SCAN, 8'h56, 16'hA5A5));
        plan.push_back(voxel_row(OP_SCAN, 8'h78, 16'h0000));
        plan.push_back(voxel_row(OP_COPY, 8'h9A, 16'hA5A5));
        // write mid-grid rewinds the raster
        plan.push_back(reg_row(REG_TARGET, 16'h0001));
        plan.push_back(voxel_row(OP_SCAN, 8'hBC, 16'h0001));

        foreach (plan[k])
        begin
            row = plan[k];
            if (row.is_write)
            begin
                wait_drained();
                write_reg(row.idx, row.value);
            end
            else
            begin
                send_voxel(row.op, row.mat, row.lab, row.typed, row.want);
            end
        end

        // Random phases, the second one with no idling on either side
        phase = 0;
        while (rand_items < RANDOM_ITEMS - MAX_DIM)
        begin
            idle_on = (phase != 1);
            run_phase(1'b0);
            phase++;
        end
        // the big grid is one long stretch with no idling at all
        idle_on = 1'b0;
        run_phase(1'b1);
        idle_on = 1'b1;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && crop_words_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
